### hw/rtl/mt19937_keystream_byte_xor_macros.svh
// Assertion macros shared by the keystream XOR RTL.
`ifndef MT19937_KEYSTREAM_BYTE_XOR_MACROS_SVH
`define MT19937_KEYSTREAM_BYTE_XOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MTK_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keystream xor: implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MTK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keystream xor: next-cycle check failed");

`endif

### hw/rtl/mtk_pkg.sv
// Constants and helper functions for the MT19937 keystream XOR block.
`timescale 1ns / 1ps
`default_nettype none

package mtk_pkg;

  // Generator geometry
  localparam int unsigned Words   = 624;
  localparam int unsigned MidOff  = 397;
  localparam int unsigned MidWrap = Words - MidOff;
  localparam int unsigned WordW   = 32;
  localparam int unsigned IdxW    = $clog2(Words);
  localparam int unsigned DataW   = 8;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Words - 1);
  localparam logic [IdxW-1:0] MidOffC  = IdxW'(MidOff);
  localparam logic [IdxW-1:0] MidWrapC = IdxW'(MidWrap);

  // Seeding and twist constants
  localparam logic [16:0]      SeedMult  = 17'h10DCD;
  localparam logic [WordW-1:0] SeedReset = 32'd381923;
  localparam logic [WordW-1:0] TwistXor  = 32'h9908_B0DF;
  localparam logic [WordW-1:0] UpperMask = 32'h8000_0000;
  localparam logic [WordW-1:0] TemperB   = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC   = 32'hEFC6_0000;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam logic        RegSeed  = 1'b0;

  // Twist one word from its own old value, its old successor and the mid word
  function automatic logic [WordW-1:0] twist_word(input logic [WordW-1:0] cur,
                                                  input logic [WordW-1:0] nxt,
                                                  input logic [WordW-1:0] mid);
    logic [WordW-1:0] y;
    logic [WordW-1:0] v;
    y = (cur & UpperMask) | (nxt & ~UpperMask);
    v = y >> 1;
    if (y[0]) begin
      v = v ^ TwistXor;
    end
    return v ^ mid;
  endfunction

  // Output tempering
  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mtk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mtk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/mt19937_keystream_byte_xor.sv
// Top level: byte stream XOR with an MT19937 keystream, state in one RAM.
`timescale 1ns / 1ps
`default_nettype none
`include "mt19937_keystream_byte_xor_macros.svh"

// Each byte transfer steps through the accept cycle, ST_R1, ST_R2 and ST_R3: the accept cycle
// issues the read of the current state word, then the successor word and the mid word are read
// through the single RAM read port, and ST_R3 twists the word, writes it back and tempers it
// into the output register, waiting there while that register is full. The twist runs one
// word at a time on demand, so a full twist never stalls the stream. The first byte after
// reset, and every byte whose restart flag (tuser) is set, first run a seeding walk over all
// 624 state words that writes one state word per cycle from the seed register, followed by
// ST_R0 to re-issue the read. A seed write affects only the next seeding. The output register
// lets the next byte be accepted while a result awaits transfer.

module mt19937_keystream_byte_xor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Byte input; tdata: data_in[7:0]; tuser: restart[0]
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [mtk_pkg::DataW-1:0]          s_axis_tdata,
  input  wire logic                               s_axis_tuser,
  // Byte output; tdata: data_out[7:0]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [mtk_pkg::DataW-1:0]          m_axis_tdata,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mtk_pkg::ApbAddrW-1:0]       paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_R0   = 3'd2;
  localparam logic [2:0] ST_R1   = 3'd3;
  localparam logic [2:0] ST_R2   = 3'd4;
  localparam logic [2:0] ST_R3   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [mtk_pkg::IdxW-1:0]       idx_q, idx_d;
  logic                           needs_seed_q, needs_seed_d;
  logic [mtk_pkg::WordW-1:0]      seed_q;
  logic [mtk_pkg::IdxW-1:0]       seed_cnt_q, seed_cnt_d;
  logic [mtk_pkg::WordW-1:0]      seed_w_q, seed_w_d;
  logic [mtk_pkg::DataW-1:0]      data_q, data_d;
  logic [mtk_pkg::WordW-1:0]      cur_q, cur_d;
  logic [mtk_pkg::WordW-1:0]      nxt_q, nxt_d;
  logic [mtk_pkg::DataW-1:0]      out_data_q, out_data_d;
  logic                           out_valid_q, out_valid_d;

  logic                           ram_we;
  logic [mtk_pkg::IdxW-1:0]       ram_waddr;
  logic [mtk_pkg::WordW-1:0]      ram_wdata;
  logic [mtk_pkg::IdxW-1:0]       ram_raddr;
  logic [mtk_pkg::WordW-1:0]      ram_rdata;

  logic [mtk_pkg::IdxW-1:0]       idx_succ;
  logic [mtk_pkg::IdxW-1:0]       idx_mid;
  logic [mtk_pkg::WordW-1:0]      seed_prod;
  logic [mtk_pkg::WordW-1:0]      new_word;
  logic [mtk_pkg::WordW-1:0]      key_word;
  logic                           in_xfer;
  logic                           out_free;
  logic                           cfg_wr;

  // Configuration register: seed
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mtk_pkg::RegSeed) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtk_pkg::SeedReset;
    end else if (cfg_wr && (paddr[2] == mtk_pkg::RegSeed)) begin
      seed_q <= pwdata;
    end
  end

  // Neighbour addresses of the current word
  assign idx_succ = (idx_q == mtk_pkg::LastIdx) ? '0 : idx_q + 1'b1;
  assign idx_mid  = (idx_q >= mtk_pkg::MidWrapC) ? idx_q - mtk_pkg::MidWrapC
                                                 : idx_q + mtk_pkg::MidOffC;

  // Shared datapath: seeding multiply, twist and temper
  assign seed_prod = seed_w_q * mtk_pkg::WordW'(mtk_pkg::SeedMult);
  assign new_word  = mtk_pkg::twist_word(cur_q, nxt_q, ram_rdata);
  assign key_word  = mtk_pkg::temper(new_word);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    needs_seed_d = needs_seed_q;
    seed_cnt_d   = seed_cnt_q;
    seed_w_d     = seed_w_q;
    data_d       = data_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = new_word;
    ram_raddr    = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          data_d = s_axis_tdata;
          if (s_axis_tuser || needs_seed_q) begin
            seed_cnt_d = '0;
            seed_w_d   = seed_q;
            state_d    = ST_SEED;
          end else begin
            state_d = ST_R1;
          end
        end
      end
      ST_SEED: begin
        ram_we     = 1'b1;
        ram_waddr  = seed_cnt_q;
        ram_wdata  = seed_w_q;
        seed_w_d   = seed_prod;
        seed_cnt_d = seed_cnt_q + 1'b1;
        if (seed_cnt_q == mtk_pkg::LastIdx) begin
          idx_d        = '0;
          needs_seed_d = 1'b0;
          state_d      = ST_R0;
        end
      end
      ST_R0: begin
        state_d = ST_R1;
      end
      ST_R1: begin
        ram_raddr = idx_succ;
        cur_d     = ram_rdata;
        state_d   = ST_R2;
      end
      ST_R2: begin
        ram_raddr = idx_mid;
        nxt_d     = ram_rdata;
        state_d   = ST_R3;
      end
      ST_R3: begin
        // hold the mid read steady while the output register is full
        ram_raddr = idx_mid;
        if (out_free) begin
          ram_we      = 1'b1;
          out_data_d  = data_q ^ key_word[mtk_pkg::DataW-1:0];
          out_valid_d = 1'b1;
          idx_d       = idx_succ;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      needs_seed_q <= 1'b1;
      seed_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      needs_seed_q <= needs_seed_d;
      seed_cnt_q   <= seed_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seed_w_q   <= seed_w_d;
    data_q     <= data_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Generator state
  mtk_ram #(
    .Width (mtk_pkg::WordW),
    .Depth (mtk_pkg::Words),
    .AddrW (mtk_pkg::IdxW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks
  `MTK_ASSERT_IMP(a_idx_range, 1'b1, idx_q <= mtk_pkg::LastIdx)
  `MTK_ASSERT_IMP(a_ram_waddr, ram_we, ram_waddr <= mtk_pkg::LastIdx)
  `MTK_ASSERT_NEXT(a_seed_entry, in_xfer && (s_axis_tuser || needs_seed_q), state_q == ST_SEED)
  `MTK_ASSERT_IMP(a_out_source, $rose(m_axis_tvalid), $past(state_q) == ST_R3)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking bench for the MT19937 keystream byte XOR block.
`timescale 1ns / 1ps

module tb_top;
  import mtk_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned IdlePct    = 12;
  localparam logic [ApbAddrW-1:0] SeedAddr = ApbAddrW'(4 * RegSeed);

  typedef struct packed {
    logic             restart;
    logic [DataW-1:0] data;
  } byte_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Byte input; tdata: data_in[7:0]; tuser: restart[0]
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  // Byte output; tdata: data_out[7:0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  // Configuration port
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  mt19937_keystream_byte_xor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Generator shadow state
  logic [WordW-1:0] gen_words [Words];
  int unsigned      gen_pos       = Words;
  logic             gen_unseeded  = 1'b1;
  logic [WordW-1:0] seed_shadow   = SeedReset;

  byte_item_t       pending_bytes [$];
  logic [DataW-1:0] expected_bytes [$];
  int unsigned      queued_n   = 0;
  int unsigned      accepted_n = 0;
  int unsigned      fault_n    = 0;
  int unsigned      cycle_n    = 0;
  logic             in_xfer    = 1'b0;
  logic             steady     = 1'b0;
  byte_item_t       next_item;
  logic [DataW-1:0] want_byte;

  // Regenerate all 624 words in place
  function automatic void regen_state();
    logic [WordW-1:0] nxt;
    logic [WordW-1:0] y;
    logic [WordW-1:0] v;
    for (int unsigned k = 0; k < Words; k++) begin
      nxt = gen_words[(k + 1) % Words];
      y   = {gen_words[k][31], nxt[30:0]};
      v   = y >> 1;
      if (y[0]) begin
        v = v ^ TwistXor;
      end
      gen_words[k] = v ^ gen_words[(k + MidOff) % Words];
    end
    gen_pos = 0;
  endfunction

  // Work out the output byte for one accepted input byte
  function automatic logic [DataW-1:0] keystream_byte(input logic restart,
                                                      input logic [DataW-1:0] data);
    logic [WordW-1:0] w;
    if (restart || gen_unseeded) begin
      w = seed_shadow;
      for (int unsigned k = 0; k < Words; k++) begin
        gen_words[k] = w;
        w = w * WordW'(SeedMult);
      end
      regen_state();
      gen_unseeded = 1'b0;
    end
    if (gen_pos >= Words) begin
      regen_state();
    end
    w = gen_words[gen_pos];
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TemperB);
    w = w ^ ((w << 15) & TemperC);
    w = w ^ (w >> 18);
    gen_pos++;
    return data ^ w[DataW-1:0];
  endfunction

  task automatic flag_fault(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (fault_n < 10) begin
      $display("mismatch: %s expected %h got %h", what, want, got);
    end
    fault_n++;
  endtask

  task automatic queue_byte(input logic restart, input logic [DataW-1:0] data);
    pending_bytes.push_back('{restart: restart, data: data});
    queued_n++;
  endtask

  // Hold until every queued byte is taken and every result is back
  task automatic wait_drained();
    while (accepted_n != queued_n || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write the seed register, then read it back
  task automatic write_seed(input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= SeedAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_shadow = value;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      flag_fault("seed readback", value, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus: directed bytes, then phases under several seeds
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // first byte seeds whatever its restart flag; then extremes and back-to-back restarts
    queue_byte(1'($urandom_range(0, 1)), 8'h00);
    queue_byte(1'b0, 8'hFF);
    queue_byte(1'b0, 8'hAA);
    queue_byte(1'b0, 8'h55);
    queue_byte(1'b1, 8'h01);
    queue_byte(1'b1, 8'h80);
    queue_byte(1'b0, 8'h7F);
    queue_byte(1'b0, 8'hFE);
    queue_byte(1'b1, 8'h0F);
    queue_byte(1'b0, 8'hF0);
    for (int i = 0; i < 6; i++) begin
      queue_byte(1'b0, 8'($urandom));
    end
    wait_drained();

    // zero seed, one long run past the end of the state so a twist falls mid-stream
    write_seed(32'h0000_0000);
    steady = 1'b1;
    queue_byte(1'b1, 8'($urandom));
    for (int i = 0; i < 650; i++) begin
      queue_byte(1'b0, 8'($urandom));
    end
    wait_drained();
    steady = 1'b0;

    // all-ones seed, frequent restarts
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 300; i++) begin
      queue_byte(1'($urandom_range(0, 19) == 0), 8'($urandom));
    end
    wait_drained();

    // random seed written mid-stream: the running keystream carries on until a restart
    write_seed($urandom);
    for (int i = 0; i < 40; i++) begin
      queue_byte(1'b0, 8'($urandom));
    end
    queue_byte(1'b1, 8'($urandom));
    for (int i = 0; i < 440; i++) begin
      queue_byte(1'($urandom_range(0, 99) == 0), 8'($urandom));
    end
    wait_drained();

    repeat (TailCycles) @(negedge clk_i);
    if (fault_n == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Drive input transfers and output back-pressure at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_xfer) begin
        if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          next_item = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data;
          s_axis_tuser  <= next_item.restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Predict on each input transfer, check each output transfer, watch the clock
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_xfer <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bytes.push_back(keystream_byte(s_axis_tuser, s_axis_tdata));
        accepted_n++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          flag_fault("unexpected data_out", 32'h0, 32'(m_axis_tdata));
        end else begin
          want_byte = expected_bytes.pop_front();
          if (m_axis_tdata !== want_byte) begin
            flag_fault("data_out", 32'(want_byte), 32'(m_axis_tdata));
          end
        end
      end
    end
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mtk_pkg.sv
hw/rtl/mtk_ram.sv
hw/rtl/mt19937_keystream_byte_xor.sv
tb/sv/tb_top.sv
